// File: sv/ttdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttdr_pkg;

    // line count is a power of two, so the line index is the low key bits
    localparam int LINE_COUNT = 1024;
    localparam int LINE_BITS  = $clog2(LINE_COUNT);
    localparam int SLOT_COUNT = 2 * LINE_COUNT;
    localparam int SLOT_BITS  = LINE_BITS + 1;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 9;
    localparam int OUTC_W  = 2;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam int RSP_DEPTH = 3;
    localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
    localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

    typedef logic [SLOT_BITS-1:0] t_slot_addr;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [DEPTH_W-1:0] depth;
        logic signed [OUTC_W-1:0]  outcome;
    } t_slot;

    typedef struct packed {
        logic                     hit;
        logic signed [OUTC_W-1:0] stored_outcome;
    } t_rsp;

endpackage

`default_nettype wire

// File: sv/ttdr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ttdr_req_if;
    import ttdr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [KEY_W-1:0]          key;
    logic                      side;
    logic signed [DEPTH_W-1:0] search_depth;
    logic signed [OUTC_W-1:0]  outcome;

    modport source (output valid, cmd, key, side, search_depth, outcome, input ready);
    modport sink   (input valid, cmd, key, side, search_depth, outcome, output ready);
endinterface

interface ttdr_rsp_if;
    import ttdr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [OUTC_W-1:0] stored_outcome;

    modport source (output valid, hit, stored_outcome, input ready);
    modport sink   (input valid, hit, stored_outcome, output ready);
endinterface

`default_nettype wire

// File: sv/ttdr_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ttdr_mem (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire ttdr_pkg::t_slot_addr i_waddr,
    input  wire ttdr_pkg::t_slot      i_wdata,
    input  wire ttdr_pkg::t_slot_addr i_raddr,
    output ttdr_pkg::t_slot           o_rdata
);
    import ttdr_pkg::*;

    t_slot r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/ttdr_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ttdr_rsp_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire ttdr_pkg::t_rsp                 i_data,
    output logic [ttdr_pkg::RSP_CNT_W-1:0]      o_count,
    ttdr_rsp_if.source                          o_rsp
);
    import ttdr_pkg::*;

    t_rsp                 r_buf [RSP_DEPTH];
    logic [RSP_PTR_W-1:0] r_wr_ptr;
    logic [RSP_PTR_W-1:0] r_rd_ptr;
    logic [RSP_CNT_W-1:0] r_count;
    logic [RSP_PTR_W-1:0] n_wr_ptr;
    logic [RSP_PTR_W-1:0] n_rd_ptr;
    logic [RSP_CNT_W-1:0] n_count;
    logic                 pop;

    assign pop                  = o_rsp.valid && o_rsp.ready;
    assign o_rsp.valid          = (r_count != '0);
    assign o_rsp.hit            = r_buf[r_rd_ptr].hit;
    assign o_rsp.stored_outcome = r_buf[r_rd_ptr].stored_outcome;
    assign o_count              = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/transposition_table_depth_replace.sv
// Transposition table, two slots per line (one per side to move), depth-preferred
// replacement. Requests arrive on i_req (cmd, key, side, search_depth, outcome) and
// every request gives exactly one response on o_rsp (hit, stored_outcome).
// Lookup: hit when the slot key equals the key, stored_outcome returned either way.
// Update: writes the slot when empty, same key, or when the new depth is greater.
// Clear: zeroes every slot. Update, clear and the unused code respond with zeros.
// Latency: a request taken at edge t has its response on o_rsp after edge t+1,
// so it can be taken at edge t+2 at the earliest.
// Throughput: one lookup or update per cycle; the slot store is a single memory
// with a one-cycle read, read in one cycle and written back in the next, with the
// last write forwarded to the following request.
// Clear: after the clear is taken, i_req.ready stays low for 1 + 2*LINE_COUNT
// cycles (2049 at the default size) while the store is swept one slot per cycle.
// Reset: the same sweep of 2*LINE_COUNT cycles runs after reset before the first
// request is taken.
// Stall: a three-entry response queue absorbs o_rsp backpressure; i_req.ready
// drops once the queue plus the request in flight would overflow it.
`timescale 1ns / 1ps
`default_nettype none

module transposition_table_depth_replace (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ttdr_req_if.sink   i_req,
    ttdr_rsp_if.source o_rsp
);
    import ttdr_pkg::*;

    logic                      r_s1_valid;
    logic [CMD_W-1:0]          r_s1_cmd;
    logic [KEY_W-1:0]          r_s1_key;
    logic signed [DEPTH_W-1:0] r_s1_depth;
    logic signed [OUTC_W-1:0]  r_s1_outcome;
    t_slot_addr                r_s1_addr;

    logic       r_fwd_valid;
    t_slot_addr r_fwd_addr;
    t_slot      r_fwd_data;

    logic       r_wipe;
    t_slot_addr r_wipe_addr;

    logic                 accept;
    t_slot_addr           rd_addr;
    t_slot                rd_data;
    t_slot                cur;
    logic                 key_match;
    logic                 upd_write;
    logic                 item_we;
    logic                 mem_we;
    t_slot_addr           mem_waddr;
    t_slot                new_slot;
    t_slot                mem_wdata;
    t_rsp                 rsp;
    logic [RSP_CNT_W-1:0] rsp_count;
    logic [RSP_CNT_W:0]   pending;
    logic                 clear_in_s1;

    assign clear_in_s1 = r_s1_valid && (r_s1_cmd == CMD_CLEAR);
    assign pending     = {1'b0, rsp_count} + {{RSP_CNT_W{1'b0}}, r_s1_valid};
    assign i_req.ready = !r_wipe && !clear_in_s1 && (pending < (RSP_CNT_W + 1)'(RSP_DEPTH));
    assign accept      = i_req.valid && i_req.ready;
    assign rd_addr     = {i_req.key[LINE_BITS-1:0], i_req.side};

    // memory reads before it writes, so the previous cycle's write is forwarded
    assign cur       = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : rd_data;
    assign key_match = (cur.key == r_s1_key);
    assign upd_write = (cur.key == '0) || key_match || (r_s1_depth > cur.depth);
    assign item_we   = r_s1_valid && (r_s1_cmd == CMD_UPDATE) && upd_write;

    always_comb begin
        new_slot.key     = r_s1_key;
        new_slot.depth   = r_s1_depth;
        new_slot.outcome = r_s1_outcome;

        mem_we    = r_wipe || item_we;
        mem_waddr = r_wipe ? r_wipe_addr : r_s1_addr;
        mem_wdata = r_wipe ? '0 : new_slot;

        rsp = '0;
        if (r_s1_cmd == CMD_LOOKUP) begin
            rsp.hit            = key_match;
            rsp.stored_outcome = cur.outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_wipe      <= 1'b1;
            r_wipe_addr <= '0;
        end else begin
            r_s1_valid  <= accept;
            r_fwd_valid <= item_we;
            if (r_wipe) begin
                r_wipe_addr <= r_wipe_addr + 1'b1;
                if (r_wipe_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    r_wipe <= 1'b0;
                end
            end else if (clear_in_s1) begin
                r_wipe      <= 1'b1;
                r_wipe_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd     <= i_req.cmd;
            r_s1_key     <= i_req.key;
            r_s1_depth   <= i_req.search_depth;
            r_s1_outcome <= i_req.outcome;
            r_s1_addr    <= rd_addr;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= new_slot;
    end

    ttdr_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ttdr_rsp_fifo u_rsp_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (rsp),
        .o_count (rsp_count),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
